@@ sv/falru_pkg.sv @@
// shared types and constants for the fully associative lru cache
`default_nettype none

package falru_pkg;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = 2;
    localparam int TAG_W    = ADDR_W - OFFSET_W;
    localparam int STAMP_W  = 32;
    localparam int COUNT_W  = 32;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [TAG_W-1:0]   tag_t;
    typedef logic [STAMP_W-1:0] stamp_t;
    typedef logic [COUNT_W-1:0] count_t;

    // one cache entry as held in the store
    typedef struct packed {
        tag_t   tag;
        stamp_t stamp;
    } entry_t;

endpackage

`default_nettype wire

@@ sv/falru_if.sv @@
// request and result channel interfaces
`default_nettype none

interface falru_req_if
    import falru_pkg::*;
();
    logic  valid;
    logic  ready;
    addr_t address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

interface falru_rsp_if
    import falru_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   hit;
    count_t hit_count;
    count_t access_count;

    modport source (output valid, output hit, output hit_count, output access_count,
                    input ready);
    modport sink   (input valid, input hit, input hit_count, input access_count,
                    output ready);
endinterface

`default_nettype wire

@@ sv/falru_store.sv @@
// tag and stamp memory, one read and one write port, registered read data
`default_nettype none

module falru_store
    import falru_pkg::*;
#(
    parameter int ENTRIES = 512,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/full_assoc_lru_cache_model.sv @@
// fully associative cache with lru replacement, scan over the entry store
// lookup: a scan of the filled entries, then a write state that loads the result; no scan while empty
// one request at a time, taken only while idle; the scan is paced by the single read port
//   of the entry store that the lookup scan walks one entry per cycle
// reset: counters and fill count cleared, store contents undefined, no clearing pass
// results wait in an output register while the next request is taken
`default_nettype none

module full_assoc_lru_cache_model
    import falru_pkg::*;
#(
    parameter int ENTRIES = 512
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    falru_req_if.sink   req,
    falru_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic [CNT_W-1:0] fill_reg;
    count_t           hits_reg;
    count_t           accesses_reg;
    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             rsp_valid_reg;

    tag_t             tag_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_last_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic             s2_last_reg;
    logic             s2_match_reg;
    stamp_t           s2_age_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] victim_idx_reg;
    stamp_t           victim_age_reg;
    logic             rsp_hit_reg;
    count_t           rsp_hits_reg;
    count_t           rsp_accesses_reg;

    logic             accept;
    logic             rd_en;
    entry_t           rd_data;
    logic             can_load;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    count_t           hits_next;

    falru_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (issue_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rd_en     = (state_reg == ST_SCAN) && (issue_cnt_reg != fill_reg);
    assign can_load  = !rsp_valid_reg || rsp.ready;
    assign wr_en     = (state_reg == ST_WRITE) && can_load;
    assign hits_next = hits_reg + COUNT_W'(hit_found_reg);

    always_comb
    begin
        if (hit_found_reg)
        begin
            wr_addr = hit_idx_reg;
        end
        else if (fill_reg != FULL)
        begin
            wr_addr = fill_reg[IDX_W-1:0];
        end
        else
        begin
            wr_addr = victim_idx_reg;
        end
        wr_data.tag   = tag_reg;
        wr_data.stamp = accesses_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            fill_reg      <= '0;
            hits_reg      <= '0;
            accesses_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= rd_en;
            s2_valid_reg <= s1_valid_reg;
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        accesses_reg  <= accesses_reg + COUNT_W'(1);
                        issue_cnt_reg <= '0;
                        state_reg     <= (fill_reg == '0) ? ST_WRITE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                    end
                    if (s2_valid_reg && s2_last_reg)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (can_load)
                    begin
                        hits_reg      <= hits_next;
                        rsp_valid_reg <= 1'b1;
                        if (!hit_found_reg && fill_reg != FULL)
                        begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan datapath: compare and age, then running match and oldest entry
    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= issue_cnt_reg[IDX_W-1:0];
        s1_last_reg  <= (issue_cnt_reg == fill_reg - CNT_W'(1));
        s2_idx_reg   <= s1_idx_reg;
        s2_last_reg  <= s1_last_reg;
        s2_match_reg <= (rd_data.tag == tag_reg);
        s2_age_reg   <= accesses_reg - rd_data.stamp;
        if (accept)
        begin
            tag_reg       <= req.address[ADDR_W-1:OFFSET_W];
            hit_found_reg <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (s2_match_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= s2_idx_reg;
            end
            if (s2_idx_reg == '0 || s2_age_reg > victim_age_reg)
            begin
                victim_idx_reg <= s2_idx_reg;
                victim_age_reg <= s2_age_reg;
            end
        end
        if (wr_en)
        begin
            rsp_hit_reg      <= hit_found_reg;
            rsp_hits_reg     <= hits_next;
            rsp_accesses_reg <= accesses_reg;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = rsp_hit_reg;
    assign rsp.hit_count    = rsp_hits_reg;
    assign rsp.access_count = rsp_accesses_reg;

endmodule

`default_nettype wire

@@ sv/falru_check.sv @@
// port checker for the lru cache, bound to the top level
`default_nettype none

module falru_check
    import falru_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   req_valid,
    input wire logic   req_ready,
    input wire logic   rsp_valid,
    input wire logic   rsp_ready,
    input wire logic   rsp_hit,
    input wire count_t rsp_hit_count,
    input wire count_t rsp_access_count
);

    count_t acc_seen_reg;
    count_t hit_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_seen_reg <= '0;
            hit_seen_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            acc_seen_reg <= rsp_access_count;
            hit_seen_reg <= rsp_hit_count;
        end
    end

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in progress");

    // every result counts exactly one more access
    a_access_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |-> (rsp_access_count == acc_seen_reg + COUNT_W'(1)))
        else $error("access count out of step");

    // hit count moves only with the hit flag
    a_hit_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |->
            (rsp_hit_count == hit_seen_reg + COUNT_W'(rsp_hit)))
        else $error("hit count out of step");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_hit) && $stable(rsp_hit_count)
             && $stable(rsp_access_count)))
        else $error("stalled result changed");

endmodule

bind full_assoc_lru_cache_model falru_check u_falru_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_hit          (rsp.hit),
    .rsp_hit_count    (rsp.hit_count),
    .rsp_access_count (rsp.access_count)
);

`default_nettype wire
